@@ sv/xmt_pkg.sv @@
// package for the xml markup tokenizer: beat types, token kinds, error codes
// no dependencies
`timescale 1ns / 1ps

package xmt_pkg;

  localparam int CHAR_BITS = 16;
  localparam int OFFSET_BITS = 32;
  localparam int LINE_BITS = 32;

  typedef enum logic [3:0] {
    K_LT = 4'd0, K_LTSLASH = 4'd1, K_GT = 4'd2, K_SLASHGT = 4'd3, K_LBRACE = 4'd4,
    K_RBRACE = 4'd5, K_EQUALS = 4'd6, K_SPACE = 4'd7, K_NAME = 4'd8, K_TEXT = 4'd9,
    K_STRING = 4'd10, K_COMMENT = 4'd11, K_CDATA = 4'd12, K_PI = 4'd13, K_ERROR = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE = 3'd0, E_EOI = 3'd1, E_BANG = 3'd2, E_SLASH = 3'd3, E_DASHES = 3'd4,
    E_UNTERM = 3'd5
  } err_t;

  typedef struct packed {
    logic [15:0] char_code;
    logic        is_letter;
    logic        is_digit;
    logic        end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] start_line;
    logic [2:0]  error_code;
    logic        final_token;
  } out_beat_t;

  // classified character: front to back
  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic eoi;
    logic ws;
    logic nstart;
    logic nmore;
    logic tstop;
    logic cr;
    logic lf;
  } cls_t;

  localparam int QDEPTH = 4;
  localparam int QABITS = $clog2(QDEPTH);

  function automatic logic [CHAR_BITS-1:0] cdata_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd1: c = "C";
      3'd2: c = "D";
      3'd3: c = "A";
      3'd4: c = "T";
      3'd5: c = "A";
      default: c = "[";
    endcase
    return CHAR_BITS'(c);
  endfunction

endpackage

@@ sv/xmt_front.sv @@
// front end: accepts character beats, classifies them, queues them
// depends on xmt_pkg
`timescale 1ns / 1ps

module xmt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  xmt_pkg::in_beat_t in_data,
  output logic             q_valid,
  input  logic             q_pop,
  output xmt_pkg::cls_t    q_data
);

  xmt_pkg::cls_t mem [xmt_pkg::QDEPTH];
  logic [xmt_pkg::QABITS-1:0] wr_ptr, rd_ptr;
  logic [xmt_pkg::QABITS:0] count;
  xmt_pkg::cls_t cls;
  logic [xmt_pkg::CHAR_BITS-1:0] c;
  logic push, pop;

  always_comb begin
    c = in_data.char_code[xmt_pkg::CHAR_BITS-1:0];
    cls.ch = c;
    cls.eoi = in_data.end_of_input;
    cls.cr = c == xmt_pkg::CHAR_BITS'(13);
    cls.lf = c == xmt_pkg::CHAR_BITS'(10);
    cls.ws = c == xmt_pkg::CHAR_BITS'(32) || c == xmt_pkg::CHAR_BITS'(9) || cls.cr || cls.lf;
    cls.nstart = in_data.is_letter || c == xmt_pkg::CHAR_BITS'(":")
                 || c == xmt_pkg::CHAR_BITS'("_");
    cls.nmore = cls.nstart || in_data.is_digit || c == xmt_pkg::CHAR_BITS'(".")
                || c == xmt_pkg::CHAR_BITS'("-");
    cls.tstop = cls.ws || cls.nstart || c == xmt_pkg::CHAR_BITS'("{")
                || c == xmt_pkg::CHAR_BITS'("}") || c == xmt_pkg::CHAR_BITS'("<")
                || c == xmt_pkg::CHAR_BITS'(">") || c == xmt_pkg::CHAR_BITS'("/")
                || c == xmt_pkg::CHAR_BITS'("=");
  end

  assign in_ready = count != (xmt_pkg::QABITS+1)'(xmt_pkg::QDEPTH);
  assign q_valid = count != '0;
  assign push = in_valid && in_ready;
  assign pop = q_pop && q_valid;
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ sv/xmt_back.sv @@
// back end: lexer state machine, emits up to two token beats per character
// depends on xmt_pkg
`timescale 1ns / 1ps

module xmt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  xmt_pkg::cls_t     q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output xmt_pkg::out_beat_t out_data
);

  typedef enum logic [12:0] {
    M_TOP = 13'h0001, M_LT = 13'h0002, M_BANG = 13'h0004, M_CDPRE = 13'h0008,
    M_DASH1 = 13'h0010, M_SLASH = 13'h0020, M_WS = 13'h0040, M_NAME = 13'h0080,
    M_TEXT = 13'h0100, M_STRING = 13'h0200, M_COMMENT = 13'h0400,
    M_CDATA = 13'h0800, M_PI = 13'h1000
  } mode_t;

  localparam int OB = xmt_pkg::OFFSET_BITS;
  localparam int LB = xmt_pkg::LINE_BITS;
  localparam int CB = xmt_pkg::CHAR_BITS;

  mode_t mode, mode_next;
  logic [2:0] pcnt, pcnt_next;
  logic [1:0] ccnt, ccnt_next;
  logic [OB-1:0] offset, offset_next, tbeg, tbeg_next;
  logic [LB-1:0] line, line_next, tline, tline_next;
  logic [CB-1:0] quote, quote_next;
  logic after_cr, after_cr_next;

  // result slots; two tokens at most from a character or from end of input
  xmt_pkg::out_beat_t slot [3];
  xmt_pkg::out_beat_t res [3];
  logic [1:0] nres, nslot, sidx;
  logic rescan;
  logic take;
  logic [CB-1:0] c;

  function automatic xmt_pkg::out_beat_t mk(input xmt_pkg::kind_t k,
      input logic [OB-1:0] s, input logic [OB-1:0] l, input logic [LB-1:0] ln,
      input xmt_pkg::err_t e, input logic f);
    xmt_pkg::out_beat_t r;
    r.token_kind = k;
    r.start_offset = 32'(s);
    r.token_length = 32'(l);
    r.start_line = 32'(ln);
    r.error_code = e;
    r.final_token = f;
    return r;
  endfunction

  // last waiting beat leaving this cycle frees the slots for the next character
  assign take = q_valid && (nslot == 2'd0 || (nslot == 2'd1 && out_ready));
  assign q_pop = take;
  assign c = q_data.ch;

  always_comb begin
    mode_next = mode;
    pcnt_next = pcnt;
    ccnt_next = ccnt;
    tbeg_next = tbeg;
    tline_next = tline;
    quote_next = quote;
    line_next = line;
    after_cr_next = after_cr;
    offset_next = offset + 1'b1;
    nres = 2'd0;
    rescan = 1'b0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    if (q_data.eoi) begin
      unique case (mode)
        M_LT: begin
          res[0] = mk(xmt_pkg::K_LT, tbeg, OB'(1), tline, xmt_pkg::E_NONE, 1'b0);
          nres = 2'd1;
        end
        M_BANG, M_CDPRE, M_DASH1: begin
          res[0] = mk(xmt_pkg::K_ERROR, tbeg, offset - tbeg, tline, xmt_pkg::E_BANG, 1'b0);
          nres = 2'd1;
        end
        M_SLASH: begin
          res[0] = mk(xmt_pkg::K_ERROR, tbeg, OB'(1), tline, xmt_pkg::E_SLASH, 1'b0);
          nres = 2'd1;
        end
        M_WS: begin
          res[0] = mk(xmt_pkg::K_SPACE, tbeg, offset - tbeg, tline, xmt_pkg::E_NONE, 1'b0);
          nres = 2'd1;
        end
        M_NAME: begin
          res[0] = mk(xmt_pkg::K_NAME, tbeg, offset - tbeg, tline, xmt_pkg::E_NONE, 1'b0);
          nres = 2'd1;
        end
        M_TEXT: begin
          res[0] = mk(xmt_pkg::K_TEXT, tbeg, offset - tbeg, tline, xmt_pkg::E_NONE, 1'b0);
          nres = 2'd1;
        end
        M_COMMENT: begin
          if (ccnt >= 2'd2)
            res[0] = mk(xmt_pkg::K_ERROR, tbeg, offset - tbeg, line, xmt_pkg::E_DASHES, 1'b0);
          else
            res[0] = mk(xmt_pkg::K_ERROR, tbeg, offset - tbeg, tline, xmt_pkg::E_UNTERM, 1'b0);
          nres = 2'd1;
        end
        M_STRING, M_CDATA, M_PI: begin
          res[0] = mk(xmt_pkg::K_ERROR, tbeg, offset - tbeg, tline, xmt_pkg::E_UNTERM, 1'b0);
          nres = 2'd1;
        end
        default: ;
      endcase
      res[nres] = mk(xmt_pkg::K_ERROR, offset, '0, line, xmt_pkg::E_EOI, 1'b1);
      nres = nres + 2'd1;
      mode_next = M_TOP;
      pcnt_next = '0;
      ccnt_next = '0;
      offset_next = '0;
      tbeg_next = '0;
      line_next = LB'(1);
      tline_next = LB'(1);
      quote_next = '0;
      after_cr_next = 1'b0;
    end else begin
      unique case (mode)
        M_LT: begin
          if (c == CB'("!")) begin
            mode_next = M_BANG;
            pcnt_next = '0;
          end else if (c == CB'("?")) begin
            mode_next = M_PI;
            ccnt_next = '0;
          end else if (c == CB'("/")) begin
            res[0] = mk(xmt_pkg::K_LTSLASH, tbeg, OB'(2), tline, xmt_pkg::E_NONE, 1'b0);
            nres = 2'd1;
            mode_next = M_TOP;
          end else begin
            res[0] = mk(xmt_pkg::K_LT, tbeg, OB'(1), tline, xmt_pkg::E_NONE, 1'b0);
            nres = 2'd1;
            rescan = 1'b1;
          end
        end
        M_BANG: begin
          if (c == CB'("[")) begin
            mode_next = M_CDPRE;
            pcnt_next = 3'd1;
          end else if (c == CB'("-")) begin
            mode_next = M_DASH1;
          end else begin
            res[0] = mk(xmt_pkg::K_ERROR, tbeg, offset - tbeg, tline, xmt_pkg::E_BANG, 1'b0);
            nres = 2'd1;
            rescan = 1'b1;
          end
        end
        M_CDPRE: begin
          if (c == xmt_pkg::cdata_char(pcnt)) begin
            if (pcnt == 3'd6) begin
              mode_next = M_CDATA;
              pcnt_next = '0;
              ccnt_next = '0;
            end else begin
              pcnt_next = pcnt + 3'd1;
            end
          end else begin
            res[0] = mk(xmt_pkg::K_ERROR, tbeg, offset - tbeg, tline, xmt_pkg::E_BANG, 1'b0);
            nres = 2'd1;
            rescan = 1'b1;
          end
        end
        M_DASH1: begin
          if (c == CB'("-")) begin
            mode_next = M_COMMENT;
            ccnt_next = '0;
          end else begin
            res[0] = mk(xmt_pkg::K_ERROR, tbeg, offset - tbeg, tline, xmt_pkg::E_BANG, 1'b0);
            nres = 2'd1;
            rescan = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CB'(">")) begin
            res[0] = mk(xmt_pkg::K_SLASHGT, tbeg, OB'(2), tline, xmt_pkg::E_NONE, 1'b0);
            nres = 2'd1;
            mode_next = M_TOP;
          end else begin
            res[0] = mk(xmt_pkg::K_ERROR, tbeg, OB'(1), tline, xmt_pkg::E_SLASH, 1'b0);
            nres = 2'd1;
            rescan = 1'b1;
          end
        end
        M_WS: begin
          if (!q_data.ws) begin
            res[0] = mk(xmt_pkg::K_SPACE, tbeg, offset - tbeg, tline, xmt_pkg::E_NONE, 1'b0);
            nres = 2'd1;
            rescan = 1'b1;
          end
        end
        M_NAME: begin
          if (!q_data.nmore) begin
            res[0] = mk(xmt_pkg::K_NAME, tbeg, offset - tbeg, tline, xmt_pkg::E_NONE, 1'b0);
            nres = 2'd1;
            rescan = 1'b1;
          end
        end
        M_TEXT: begin
          if (q_data.tstop) begin
            res[0] = mk(xmt_pkg::K_TEXT, tbeg, offset - tbeg, tline, xmt_pkg::E_NONE, 1'b0);
            nres = 2'd1;
            rescan = 1'b1;
          end
        end
        M_STRING: begin
          if (c == quote) begin
            res[0] = mk(xmt_pkg::K_STRING, tbeg, offset_next - tbeg, tline,
                        xmt_pkg::E_NONE, 1'b0);
            nres = 2'd1;
            mode_next = M_TOP;
          end
        end
        M_COMMENT: begin
          if (ccnt >= 2'd2) begin
            ccnt_next = '0;
            if (c == CB'(">")) begin
              res[0] = mk(xmt_pkg::K_COMMENT, tbeg, offset_next - tbeg, tline,
                          xmt_pkg::E_NONE, 1'b0);
              nres = 2'd1;
              mode_next = M_TOP;
            end else begin
              res[0] = mk(xmt_pkg::K_ERROR, tbeg, offset - tbeg, line, xmt_pkg::E_DASHES, 1'b0);
              nres = 2'd1;
              rescan = 1'b1;
            end
          end else begin
            ccnt_next = (c == CB'("-")) ? ccnt + 2'd1 : 2'd0;
          end
        end
        M_CDATA: begin
          if (c == CB'(">") && ccnt >= 2'd2) begin
            res[0] = mk(xmt_pkg::K_CDATA, tbeg, offset_next - tbeg, tline, xmt_pkg::E_NONE, 1'b0);
            nres = 2'd1;
            mode_next = M_TOP;
            ccnt_next = '0;
          end else if (c == CB'("]")) begin
            if (ccnt < 2'd2) ccnt_next = ccnt + 2'd1;
          end else begin
            ccnt_next = '0;
          end
        end
        M_PI: begin
          if (c == CB'(">") && ccnt >= 2'd1) begin
            res[0] = mk(xmt_pkg::K_PI, tbeg, offset_next - tbeg, tline, xmt_pkg::E_NONE, 1'b0);
            nres = 2'd1;
            mode_next = M_TOP;
            ccnt_next = '0;
          end else begin
            ccnt_next = (c == CB'("?")) ? 2'd1 : 2'd0;
          end
        end
        default: rescan = 1'b1;
      endcase
      if (rescan) begin
        tbeg_next = offset;
        tline_next = line;
        mode_next = M_TOP;
        priority if (c == CB'("<")) mode_next = M_LT;
        else if (c == CB'("/")) mode_next = M_SLASH;
        else if (c == CB'(">") || c == CB'("{") || c == CB'("}") || c == CB'("=")) begin
          res[nres] = mk(c == CB'(">") ? xmt_pkg::K_GT :
                         c == CB'("{") ? xmt_pkg::K_LBRACE :
                         c == CB'("}") ? xmt_pkg::K_RBRACE : xmt_pkg::K_EQUALS,
                         offset, OB'(1), line, xmt_pkg::E_NONE, 1'b0);
          nres = nres + 2'd1;
        end
        else if (q_data.ws) mode_next = M_WS;
        else if (c == CB'(34) || c == CB'(39)) begin
          mode_next = M_STRING;
          quote_next = c;
        end
        else if (q_data.nstart) mode_next = M_NAME;
        else mode_next = M_TEXT;
      end
      if (q_data.cr) begin
        line_next = line + 1'b1;
        after_cr_next = 1'b1;
      end else begin
        if (q_data.lf && !after_cr) line_next = line + 1'b1;
        after_cr_next = 1'b0;
      end
    end
  end

  assign out_valid = nslot != 2'd0;
  assign out_data = slot[sidx];

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) slot[i] <= res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_TOP;
      pcnt <= '0;
      ccnt <= '0;
      offset <= '0;
      tbeg <= '0;
      line <= LB'(1);
      tline <= LB'(1);
      quote <= '0;
      after_cr <= 1'b0;
      nslot <= '0;
      sidx <= '0;
    end else begin
      if (take) begin
        mode <= mode_next;
        pcnt <= pcnt_next;
        ccnt <= ccnt_next;
        offset <= offset_next;
        tbeg <= tbeg_next;
        line <= line_next;
        tline <= tline_next;
        quote <= quote_next;
        after_cr <= after_cr_next;
        nslot <= nres;
        sidx <= '0;
      end else if (out_valid && out_ready) begin
        nslot <= nslot - 2'd1;
        sidx <= sidx + 2'd1;
      end
    end
  end

endmodule

@@ sv/xml_markup_tokenizer.sv @@
// top level of the xml markup tokenizer: front classifier and queue, back lexer
// depends on xmt_pkg, xmt_front, xmt_back
`timescale 1ns / 1ps

// One character beat is taken per cycle while the back end has no tokens
// waiting, or while its last waiting token beat is being handed out. A
// character that ends tokens loads one or two token beats into the output
// slots, so with a ready output the rate is one character per cycle; a
// character or end of input that yields two tokens holds the back end until
// the first beat has left, and output stalls hold it for as long as they
// last. A four-entry queue between classifier and lexer absorbs the stalls.
module xml_markup_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  xmt_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output xmt_pkg::out_beat_t out_data
);

  logic q_valid, q_pop;
  xmt_pkg::cls_t q_data;

  xmt_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  xmt_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
